### sv/bpsk31_varicode_modulator_assert.svh
// Assertion macros shared by the modulator's checker.
// Each macro names a clocked implication that is off while reset is held.
`ifndef BPSK31_VARICODE_MODULATOR_ASSERT_SVH
`define BPSK31_VARICODE_MODULATOR_ASSERT_SVH

// Same-cycle implication.
`define BVM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define BVM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

### sv/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// Shared types, constants and tables of the BPSK31 varicode modulator.
// ----------------------------------------------------------------------------
package bvm_pkg;

  localparam int SINE_TABLE_BITS = 10;
  localparam int QBITS = SINE_TABLE_BITS - 2;
  localparam int QLUT_DEPTH = 1 << QBITS;

  localparam logic [5:0] PREAMBLE_LIMIT = 6'd33;
  localparam logic [5:0] POSTAMBLE_LIMIT = 6'd31;
  localparam logic [5:0] AMBLE_MAX = 6'd63;

  // Queue kinds.
  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_IDLE = 2'd1;
  localparam logic [1:0] KIND_END = 2'd2;

  // Register indexes.
  localparam logic [1:0] REG_CARRIER_STEP = 2'd0;
  localparam logic [1:0] REG_SYMBOL_STEP = 2'd1;
  localparam logic [1:0] REG_RAMP_STEP = 2'd2;

  localparam logic [31:0] CARRIER_STEP_RST = 32'd536870912;
  localparam logic [31:0] SYMBOL_STEP_RST = 32'd16777216;
  localparam logic [15:0] RAMP_STEP_RST = 16'd255;

  localparam logic signed [16:0] M_POS = 17'sd32768;
  localparam logic signed [16:0] M_NEG = -17'sd32768;
  localparam logic signed [15:0] AMP_Q15 = 16'sd9830;

  typedef struct packed {
    logic [31:0] carrier_step;
    logic [31:0] symbol_step;
    logic [15:0] ramp_step;
  } cfg_t;

  // Data handed from the sequencer to the mixer.
  typedef struct packed {
    logic signed [16:0] sum;
    logic signed [16:0] mult;
    logic               taken;
    logic               start;
    logic               done;
  } s1_t;

  typedef logic [14:0] qlut_t [QLUT_DEPTH];
  typedef logic [15:0] vc_lut_t [128];
  typedef logic [9:0] vc_raw_t [128];

  // Quarter-wave sine, Q1.15, from the odd polynomial evaluated at elaboration.
  function automatic qlut_t build_qlut();
    qlut_t       lut;
    logic [63:0] z;
    logic [63:0] z2;
    logic [63:0] p;
    logic [63:0] s;
    for (int i = 0; i < QLUT_DEPTH; i++) begin
      z = 64'(i) << (16 - QBITS);
      z2 = (z * z) >> 16;
      p = 64'd43068;
      p = 64'd1256750 - ((p * z2) >> 16);
      p = 64'd21392326 - ((p * z2) >> 16);
      p = 64'd173399667 - ((p * z2) >> 16);
      p = 64'd421657428 - ((p * z2) >> 16);
      s = (((p * z) >> 16) + 64'd4096) >> 13;
      if (s > 64'd32767) begin
        s = 64'd32767;
      end
      lut[i] = s[14:0];
    end
    return lut;
  endfunction

  localparam qlut_t QSIN_LUT = build_qlut();

  // Sine of idx / 2^SINE_TABLE_BITS of a full circle.
  function automatic logic signed [15:0] qsin(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [1:0]       quad;
    logic [QBITS:0]   r;
    logic [15:0]      mag;
    quad = idx[SINE_TABLE_BITS-1 -: 2];
    r = {1'b0, idx[QBITS-1:0]};
    if (quad[0]) begin
      r = (QBITS + 1)'(QLUT_DEPTH) - r;
    end
    if (r[QBITS]) begin
      mag = 16'd32767;
    end else begin
      mag = {1'b0, QSIN_LUT[r[QBITS-1:0]]};
    end
    return quad[1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [15:0] qcos(input logic [SINE_TABLE_BITS-1:0] idx);
    logic [SINE_TABLE_BITS-1:0] shifted;
    shifted = idx + SINE_TABLE_BITS'(QLUT_DEPTH);
    return qsin(shifted);
  endfunction

  // Varicode of ASCII 0..127, right aligned.
  localparam vc_raw_t VARICODE_RAW = '{
    10'b1010101011, 10'b1011011011, 10'b1011101101, 10'b1101110111,
    10'b1011101011, 10'b1101011111, 10'b1011101111, 10'b1011111101,
    10'b1011111111, 10'b11101111, 10'b11101, 10'b1101101111,
    10'b1011011101, 10'b11111, 10'b1101110101, 10'b1110101011,
    10'b1011110111, 10'b1011110101, 10'b1110101101, 10'b1110101111,
    10'b1101011011, 10'b1101101011, 10'b1101101101, 10'b1101010111,
    10'b1101111011, 10'b1101111101, 10'b1110110111, 10'b1101010101,
    10'b1101011101, 10'b1110111011, 10'b1011111011, 10'b1101111111,
    10'b1, 10'b111111111, 10'b101011111, 10'b111110101,
    10'b111011011, 10'b1011010101, 10'b1010111011, 10'b101111111,
    10'b11111011, 10'b11110111, 10'b101101111, 10'b111011111,
    10'b1110101, 10'b110101, 10'b1010111, 10'b110101111,
    10'b10110111, 10'b10111101, 10'b11101101, 10'b11111111,
    10'b101110111, 10'b101011011, 10'b101101011, 10'b110101101,
    10'b110101011, 10'b110110111, 10'b11110101, 10'b110111101,
    10'b111101101, 10'b1010101, 10'b111010111, 10'b1010101111,
    10'b1010111101, 10'b1111101, 10'b11101011, 10'b10101101,
    10'b10110101, 10'b1110111, 10'b11011011, 10'b11111101,
    10'b101010101, 10'b1111111, 10'b111111101, 10'b101111101,
    10'b11010111, 10'b10111011, 10'b11011101, 10'b10101011,
    10'b11010101, 10'b111011101, 10'b10101111, 10'b1101111,
    10'b1101101, 10'b101010111, 10'b110110101, 10'b101011101,
    10'b101110101, 10'b101111011, 10'b1010101101, 10'b111110111,
    10'b111101111, 10'b111111011, 10'b1010111111, 10'b101101101,
    10'b1011011111, 10'b1011, 10'b1011111, 10'b101111,
    10'b101101, 10'b11, 10'b111101, 10'b1011011,
    10'b101011, 10'b1101, 10'b111101011, 10'b10111111,
    10'b11011, 10'b111011, 10'b1111, 10'b111,
    10'b111111, 10'b110111111, 10'b10101, 10'b10111,
    10'b101, 10'b110111, 10'b1111011, 10'b1101011,
    10'b11011111, 10'b1011101, 10'b111010101, 10'b1010110111,
    10'b110111011, 10'b1010110101, 10'b1011010111, 10'b1110110101
  };

  // Left-justify each code so that its first bit sits at bit 15.
  function automatic vc_lut_t build_vc_lut();
    vc_lut_t     lut;
    logic [15:0] v;
    for (int i = 0; i < 128; i++) begin
      v = {6'd0, VARICODE_RAW[i]};
      for (int k = 0; k < 16; k++) begin
        if (v != 16'd0 && !v[15]) begin
          v = v << 1;
        end
      end
      lut[i] = v;
    end
    return lut;
  endfunction

  localparam vc_lut_t VARICODE_LUT = build_vc_lut();

endpackage

### sv/bpsk31_varicode_modulator.sv
// ----------------------------------------------------------------------------
// bpsk31_varicode_modulator
// Path: an accepted transaction passes the s1 register, the envelope register and then the result register.
// Throughput: one transaction per cycle through a three-register pipeline, unless a stalled result holds it up.
// Reset: synchronous, active low; restores the default settings and resets the sequencer state and valids.
// ----------------------------------------------------------------------------
module bpsk31_varicode_modulator (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel: one sample tick carrying the head of the text queue.
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_next_char,
  input  logic [1:0]         in_next_kind,
  // Result channel: one carrier sample per tick.
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_char_taken,
  output logic               out_symbol_start,
  output logic               out_done_res,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  bvm_pkg::cfg_t cfg;
  bvm_pkg::s1_t  s1;
  logic          accept;
  logic          in_hold;

  // The input side only waits when every pipeline stage holds a sample and
  // the result channel is stalled, so a waiting result does not stop intake
  // while there is still room in the pipeline.
  assign in_stall = in_hold;
  assign accept = in_valid && !in_hold;

  bvm_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // First stage: all per-tick state advances here, once per accepted
  // transaction. The symbol timer carry selects a new bit, the bit decides
  // whether the phase flips, and the flip is shaped by the ramp cosine. The
  // carrier cos+sin sum is looked up from the phase before its increment.
  bvm_sequencer u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .accept    (accept),
    .next_char (in_next_char),
    .next_kind (in_next_kind),
    .s1        (s1)
  );

  // Second and third stages: the envelope multiply, then the 0.3 amplitude
  // scale, each rounded half away from zero, with the result register last.
  bvm_mixer u_mix (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .s1               (s1),
    .in_hold          (in_hold),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sample       (out_sample),
    .out_char_taken   (out_char_taken),
    .out_symbol_start (out_symbol_start),
    .out_done_res     (out_done_res)
  );

endmodule

### sv/bvm_cfg_regs.sv
// ----------------------------------------------------------------------------
// bvm_cfg_regs
// APB-style register file holding the carrier, symbol and ramp steps.
// ----------------------------------------------------------------------------
module bvm_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           psel,
  input  logic           penable,
  input  logic           pwrite,
  input  logic [3:0]     paddr,
  input  logic [31:0]    pwdata,
  output logic [31:0]    prdata,
  output logic           pready,
  output bvm_pkg::cfg_t  cfg
);

  bvm_pkg::cfg_t cfg_r;
  bvm_pkg::cfg_t cfg_nxt;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[3:2])
        bvm_pkg::REG_CARRIER_STEP: cfg_nxt.carrier_step = pwdata;
        bvm_pkg::REG_SYMBOL_STEP:  cfg_nxt.symbol_step = pwdata;
        bvm_pkg::REG_RAMP_STEP:    cfg_nxt.ramp_step = pwdata[15:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      bvm_pkg::REG_CARRIER_STEP: prdata = cfg_r.carrier_step;
      bvm_pkg::REG_SYMBOL_STEP:  prdata = cfg_r.symbol_step;
      bvm_pkg::REG_RAMP_STEP:    prdata = {16'd0, cfg_r.ramp_step};
      default: prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.carrier_step <= bvm_pkg::CARRIER_STEP_RST;
      cfg_r.symbol_step <= bvm_pkg::SYMBOL_STEP_RST;
      cfg_r.ramp_step <= bvm_pkg::RAMP_STEP_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### sv/bvm_sequencer.sv
// ----------------------------------------------------------------------------
// bvm_sequencer
// Symbol timer, bit source, phase and ramp state, and the table lookups.
// ----------------------------------------------------------------------------
module bvm_sequencer (
  input  logic           clk,
  input  logic           rst_n,
  input  bvm_pkg::cfg_t  cfg,
  input  logic           accept,
  input  logic [7:0]     next_char,
  input  logic [1:0]     next_kind,
  output bvm_pkg::s1_t   s1
);

  localparam logic [2:0] MODE_OFF = 3'd0;
  localparam logic [2:0] MODE_PRE = 3'd1;
  localparam logic [2:0] MODE_SEND = 3'd2;
  localparam logic [2:0] MODE_POST = 3'd3;
  localparam logic [2:0] MODE_END = 3'd4;
  localparam int TB = bvm_pkg::SINE_TABLE_BITS;

  logic [31:0] carrier_phase_r, carrier_phase_nxt;
  logic [31:0] symbol_timer_r, symbol_timer_nxt;
  logic [16:0] ramp_angle_r, ramp_angle_nxt;
  logic [15:0] bit_shifter_r, bit_shifter_nxt;
  logic        ending_zero_due_r, ending_zero_due_nxt;
  logic [2:0]  tx_mode_r, tx_mode_nxt;
  logic [5:0]  amble_count_r, amble_count_nxt;
  logic        phase_is_180_r, phase_is_180_nxt;
  logic        reversing_r, reversing_nxt;
  bvm_pkg::s1_t s1_r, s1_nxt;

  logic [32:0]        timer_sum;
  logic [16:0]        ramp_cur;
  logic               bit_val;
  logic               taken_nxt;
  logic               start_nxt;
  logic               done_nxt;
  logic signed [15:0] ramp_cos;
  logic signed [15:0] car_cos;
  logic signed [15:0] car_sin;

  assign s1 = s1_r;
  assign car_cos = bvm_pkg::qcos(carrier_phase_r[31 -: TB]);
  assign car_sin = bvm_pkg::qsin(carrier_phase_r[31 -: TB]);

  always_comb begin
    carrier_phase_nxt = carrier_phase_r + cfg.carrier_step;
    symbol_timer_nxt = symbol_timer_r;
    ramp_angle_nxt = ramp_angle_r;
    bit_shifter_nxt = bit_shifter_r;
    ending_zero_due_nxt = ending_zero_due_r;
    tx_mode_nxt = tx_mode_r;
    amble_count_nxt = amble_count_r;
    phase_is_180_nxt = phase_is_180_r;
    reversing_nxt = reversing_r;
    taken_nxt = 1'b0;
    start_nxt = 1'b0;
    done_nxt = 1'b0;
    bit_val = 1'b0;
    ramp_cur = ramp_angle_r;
    timer_sum = {1'b0, symbol_timer_r} + {1'b0, cfg.symbol_step};

    if (tx_mode_r >= MODE_END) begin
      done_nxt = 1'b1;
    end else begin
      symbol_timer_nxt = timer_sum[31:0];
      if (timer_sum[32]) begin
        start_nxt = 1'b1;
        ramp_cur = 17'd0;
        if (bit_shifter_r != 16'd0) begin
          bit_val = bit_shifter_r[15];
          bit_shifter_nxt = {bit_shifter_r[14:0], 1'b0};
          if (bit_shifter_r[14:0] == 15'd0) begin
            ending_zero_due_nxt = 1'b1;
          end
        end else if (ending_zero_due_r) begin
          ending_zero_due_nxt = 1'b0;
        end else begin
          case (tx_mode_r)
            MODE_OFF: begin
              tx_mode_nxt = MODE_PRE;
              amble_count_nxt = 6'd1;
            end
            MODE_PRE: begin
              amble_count_nxt = amble_count_r + 6'd1;
              if (amble_count_r >= bvm_pkg::PREAMBLE_LIMIT) begin
                amble_count_nxt = 6'd0;
                tx_mode_nxt = MODE_SEND;
              end
            end
            MODE_SEND: begin
              if (next_kind == bvm_pkg::KIND_CHAR) begin
                taken_nxt = 1'b1;
                bit_shifter_nxt = bvm_pkg::VARICODE_LUT[next_char[6:0]];
              end else if (next_kind == bvm_pkg::KIND_END) begin
                taken_nxt = 1'b1;
                tx_mode_nxt = MODE_POST;
                amble_count_nxt = 6'd0;
              end
            end
            default: begin
              // Postamble: the count saturates at AMBLE_MAX; passing POSTAMBLE_LIMIT or saturation ends it.
              if (amble_count_r < bvm_pkg::AMBLE_MAX) begin
                amble_count_nxt = amble_count_r + 6'd1;
              end
              if (amble_count_r > bvm_pkg::POSTAMBLE_LIMIT ||
                  amble_count_r == bvm_pkg::AMBLE_MAX) begin
                tx_mode_nxt = MODE_END;
                bit_val = 1'b1;
              end
            end
          endcase
        end

        if (tx_mode_nxt >= MODE_END) begin
          done_nxt = 1'b1;
          phase_is_180_nxt = 1'b1;
          reversing_nxt = 1'b0;
        end else if (!bit_val) begin
          reversing_nxt = 1'b1;
          phase_is_180_nxt = !phase_is_180_r;
        end else begin
          reversing_nxt = 1'b0;
        end
      end
      ramp_angle_nxt = ramp_cur + {1'b0, cfg.ramp_step};
    end
  end

  assign ramp_cos = bvm_pkg::qcos(ramp_cur[16 -: TB]);

  always_comb begin
    s1_nxt.taken = taken_nxt;
    s1_nxt.start = start_nxt;
    s1_nxt.done = done_nxt;
    if (done_nxt) begin
      s1_nxt.mult = bvm_pkg::M_NEG;
    end else if (reversing_nxt) begin
      s1_nxt.mult = phase_is_180_nxt ? 17'(ramp_cos) : -17'(ramp_cos);
    end else begin
      s1_nxt.mult = phase_is_180_nxt ? bvm_pkg::M_NEG : bvm_pkg::M_POS;
    end
    s1_nxt.sum = 17'(car_cos) + 17'(car_sin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      carrier_phase_r <= 32'd0;
      symbol_timer_r <= 32'hFFFF_FFFF;
      ramp_angle_r <= 17'd0;
      bit_shifter_r <= 16'd0;
      ending_zero_due_r <= 1'b0;
      tx_mode_r <= MODE_OFF;
      amble_count_r <= 6'd0;
      phase_is_180_r <= 1'b1;
      reversing_r <= 1'b0;
    end else if (accept) begin
      carrier_phase_r <= carrier_phase_nxt;
      symbol_timer_r <= symbol_timer_nxt;
      ramp_angle_r <= ramp_angle_nxt;
      bit_shifter_r <= bit_shifter_nxt;
      ending_zero_due_r <= ending_zero_due_nxt;
      tx_mode_r <= tx_mode_nxt;
      amble_count_r <= amble_count_nxt;
      phase_is_180_r <= phase_is_180_nxt;
      reversing_r <= reversing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

### sv/bvm_mixer.sv
// ----------------------------------------------------------------------------
// bvm_mixer
// Two multiply stages that scale the carrier sum and drive the result channel.
// ----------------------------------------------------------------------------
module bvm_mixer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  bvm_pkg::s1_t       s1,
  output logic               in_hold,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               out_char_taken,
  output logic               out_symbol_start,
  output logic               out_done_res
);

  logic v1_r, v2_r, v3_r;
  logic adv2, adv3;

  logic signed [33:0] prod1;
  logic [33:0]        mag1;
  logic [18:0]        rnd1;
  logic signed [17:0] v_nxt;
  logic signed [17:0] env_r;
  logic [2:0]         flags2_r;

  logic signed [33:0] prod2;
  logic [33:0]        mag2;
  logic [18:0]        rnd2;
  logic signed [15:0] sample_nxt;
  logic signed [15:0] sample_r;
  logic [2:0]         flags3_r;

  // A stage moves on when the one after it is empty or moving on too.
  assign adv3 = !v3_r || !out_stall;
  assign adv2 = !v2_r || adv3;
  assign in_hold = v1_r && !adv2;

  // Round half away from zero by 2^15.
  always_comb begin
    prod1 = s1.sum * s1.mult;
    mag1 = prod1[33] ? 34'(-prod1) : 34'(prod1);
    rnd1 = 19'((mag1 + 34'd16384) >> 15);
    v_nxt = prod1[33] ? -$signed(rnd1[17:0]) : $signed(rnd1[17:0]);
  end

  always_comb begin
    prod2 = env_r * bvm_pkg::AMP_Q15;
    mag2 = prod2[33] ? 34'(-prod2) : 34'(prod2);
    rnd2 = 19'((mag2 + 34'd16384) >> 15);
    if (!prod2[33]) begin
      sample_nxt = (rnd2 > 19'd32767) ? 16'sd32767 : $signed(rnd2[15:0]);
    end else begin
      sample_nxt = (rnd2 > 19'd32768) ? -16'sd32768 : -$signed(rnd2[15:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= accept || (v1_r && !adv2);
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      env_r <= v_nxt;
      flags2_r <= {s1.taken, s1.start, s1.done};
    end
    if (adv3) begin
      sample_r <= sample_nxt;
      flags3_r <= flags2_r;
    end
  end

  assign out_valid = v3_r;
  assign out_sample = sample_r;
  assign out_char_taken = flags3_r[2];
  assign out_symbol_start = flags3_r[1];
  assign out_done_res = flags3_r[0];

endmodule

### sv/bvm_checker.sv
// ----------------------------------------------------------------------------
// bvm_checker
// Port-level checks of the modulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "bpsk31_varicode_modulator_assert.svh"

module bvm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] out_sample,
  input logic               out_char_taken,
  input logic               out_symbol_start,
  input logic               out_done_res
);

  // A stalled result stays put.
  `BVM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sample))

  // Intake only stops when the pipeline is full behind a stalled result.
  `BVM_ASSERT_NOW(a_stall_full, in_stall, out_valid && out_stall)

  // A character is only consumed when a new symbol begins.
  `BVM_ASSERT_NOW(a_taken_start, out_valid && out_char_taken, out_symbol_start)

  // Nothing is consumed once the postamble is finished.
  `BVM_ASSERT_NOW(a_done_idle, out_valid && out_done_res, !out_char_taken)

endmodule

bind bpsk31_varicode_modulator bvm_checker u_chk (.*);
